[rtl/core/r0split_pkg.sv]
`timescale 1ns / 1ps
// Types and constants shared by the RAID-0 stripe splitter.
package r0split_pkg;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 4;

	localparam logic [CFG_INDEX_W-1:0] CFG_DISK_SHIFT   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STRIPE_SHIFT = 1'b1;

	localparam logic [1:0]  DISK_SHIFT_RESET   = 2'd1;
	localparam logic [3:0]  STRIPE_SHIFT_RESET = 4'd6;
	localparam logic [1:0]  DISK_SHIFT_MIN     = 2'd1;
	localparam logic [1:0]  DISK_SHIFT_MAX     = 2'd2;
	localparam logic [3:0]  STRIPE_SHIFT_MIN   = 4'd6;
	localparam logic [11:0] MAX_COUNT          = 12'd2048;

	typedef struct packed {
		logic        func;
		logic [31:0] start_sector;
		logic [11:0] sector_count;
	} req_t;

	typedef struct packed {
		logic [1:0]  disk_index;
		logic [31:0] phys_sector;
		logic [11:0] piece_count;
		logic [10:0] buffer_offset;
		logic        is_write;
		logic        last;
	} piece_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic last_piece;
	} dp_sts_t;

endpackage

[rtl/core/r0split_datapath.sv]
`timescale 1ns / 1ps
// Splitter datapath: config registers, request walk registers and piece register.
module r0split_datapath #(
	parameter int SECTOR_ADDR_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [r0split_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [r0split_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  r0split_pkg::req_t                   req,
	input  r0split_pkg::dp_cmd_t                cmd,
	output r0split_pkg::dp_sts_t                sts,
	output r0split_pkg::piece_t                 piece
);

	localparam int AW = SECTOR_ADDR_BITS;

	logic [1:0]      disk_shift_q;
	logic [3:0]      stripe_shift_q;
	logic [AW-1:0]   cur_q;
	logic [11:0]     left_q;
	logic [10:0]     done_q;
	logic            dir_q;
	r0split_pkg::piece_t piece_s1;

	logic [1:0]      ds_eff;
	logic [3:0]      ss_eff;
	logic [4:0]      hi_shift;
	logic [1:0]      dmask;
	logic [AW-1:0]   off_mask;
	logic [AW-1:0]   off_w;
	logic [AW-1:0]   stripe_w;
	logic [AW-1:0]   phys_w;
	logic [AW+31:0]  start_ext;
	logic [AW+31:0]  phys_ext;
	logic [16:0]     room;
	logic            room_short;
	logic [11:0]     piece_cnt;
	logic [11:0]     cnt_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_shift_q   <= r0split_pkg::DISK_SHIFT_RESET;
			stripe_shift_q <= r0split_pkg::STRIPE_SHIFT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				r0split_pkg::CFG_DISK_SHIFT:   disk_shift_q   <= cfg_data[1:0];
				r0split_pkg::CFG_STRIPE_SHIFT: stripe_shift_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (disk_shift_q < r0split_pkg::DISK_SHIFT_MIN)
			ds_eff = r0split_pkg::DISK_SHIFT_MIN;
		else if (disk_shift_q > r0split_pkg::DISK_SHIFT_MAX)
			ds_eff = r0split_pkg::DISK_SHIFT_MAX;
		else
			ds_eff = disk_shift_q;
		ss_eff = (stripe_shift_q < r0split_pkg::STRIPE_SHIFT_MIN) ?
			r0split_pkg::STRIPE_SHIFT_MIN : stripe_shift_q;
	end

	assign dmask    = (ds_eff == r0split_pkg::DISK_SHIFT_MAX) ? 2'b11 : 2'b01;
	assign hi_shift = {1'b0, ss_eff} + {3'b000, ds_eff};
	assign off_mask = ({{(AW-1){1'b0}}, 1'b1} << ss_eff) - {{(AW-1){1'b0}}, 1'b1};
	assign off_w    = cur_q & off_mask;
	assign stripe_w = cur_q >> ss_eff;
	assign phys_w   = ((cur_q >> hi_shift) << ss_eff) | off_w;
	assign phys_ext = {32'd0, phys_w};

	assign room       = (17'd1 << ss_eff) - {1'b0, off_w[15:0]};
	assign room_short = room < {5'd0, left_q};
	assign piece_cnt  = room_short ? room[11:0] : left_q;

	assign start_ext = {{AW{1'b0}}, req.start_sector};
	assign cnt_sat   = (req.sector_count > r0split_pkg::MAX_COUNT) ?
		r0split_pkg::MAX_COUNT : req.sector_count;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q  <= start_ext[AW-1:0];
			left_q <= cnt_sat;
			done_q <= '0;
			dir_q  <= req.func;
		end else if (cmd.step) begin
			cur_q  <= cur_q + {{(AW-12){1'b0}}, piece_cnt};
			left_q <= left_q - piece_cnt;
			done_q <= done_q + piece_cnt[10:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			piece_s1.disk_index    <= stripe_w[1:0] & dmask;
			piece_s1.phys_sector   <= phys_ext[31:0];
			piece_s1.piece_count   <= piece_cnt;
			piece_s1.buffer_offset <= done_q;
			piece_s1.is_write      <= dir_q;
			piece_s1.last          <= !room_short;
		end
	end

	assign sts.cnt_zero   = (req.sector_count == 12'd0);
	assign sts.last_piece = !room_short;
	assign piece          = piece_s1;

endmodule

[rtl/core/r0split_ctrl.sv]
`timescale 1ns / 1ps
// Splitter controller: request/piece handshakes and walk sequencing.
module r0split_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 piece_valid,
	input  logic                 piece_ready,
	input  r0split_pkg::dp_sts_t sts,
	output r0split_pkg::dp_cmd_t cmd
);

	r0split_pkg::state_t state_q;
	r0split_pkg::state_t state_d;
	logic                out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= r0split_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step)
				out_valid_q <= 1'b1;
			else if (piece_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd.load  = 1'b0;
		cmd.step  = 1'b0;
		case (state_q)
			r0split_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					if (!sts.cnt_zero)
						state_d = r0split_pkg::ST_RUN;
				end
			end
			r0split_pkg::ST_RUN: begin
				if (!out_valid_q || piece_ready) begin
					cmd.step = 1'b1;
					if (sts.last_piece)
						state_d = r0split_pkg::ST_IDLE;
				end
			end
			default: state_d = r0split_pkg::ST_IDLE;
		endcase
	end

	assign piece_valid = out_valid_q;

endmodule

[rtl/core/raid0_stripe_request_splitter.sv]
`timescale 1ns / 1ps
// Top level of the RAID-0 stripe request splitter.
//
//  channel | direction | handshake                 | payload
//  req     | in        | req_valid / req_ready     | r0split_pkg::req_t
//  piece   | out       | piece_valid / piece_ready | r0split_pkg::piece_t
//  cfg     | in        | cfg_we                    | cfg_index, cfg_data
//
// A request is loaded, then walked as 1 to 33 pieces; the single piece register
// steps the walk once a cycle unless the piece output is stalled.
// The next request is taken once the last piece has been registered.
// A stalled piece register holds the walk. Reset clears the controller and
// sets disk_shift to 1 and stripe_shift to 6. A zero-count request yields nothing.
module raid0_stripe_request_splitter #(
	parameter int SECTOR_ADDR_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  r0split_pkg::req_t                   req,
	output logic                                piece_valid,
	input  logic                                piece_ready,
	output r0split_pkg::piece_t                 piece,
	input  logic                                cfg_we,
	input  logic [r0split_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [r0split_pkg::CFG_DATA_W-1:0]  cfg_data
);

	r0split_pkg::dp_cmd_t cmd;
	r0split_pkg::dp_sts_t sts;

	r0split_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.piece_valid (piece_valid),
		.piece_ready (piece_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	r0split_datapath #(
		.SECTOR_ADDR_BITS (SECTOR_ADDR_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.piece     (piece)
	);

	a_load_step_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.step))
		else $error("load and step in the same cycle");

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && !sts.cnt_zero |=> !req_ready)
		else $error("request taken while a walk is in progress");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && sts.last_piece |=> req_ready && piece_valid && piece.last)
		else $error("last piece did not end the walk");

	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && sts.cnt_zero |=> req_ready)
		else $error("zero-count item started a walk");

endmodule
